### sv/rsi_pkg.sv
package rsi_pkg;

    // default number of fraction bits on the fixed point ports
    localparam int FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_CENTER_Z  = 3'd2,
        REG_RADIUS    = 3'd3,
        REG_MATERIAL  = 3'd4
    } cfg_reg_t;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    // field widths
    localparam int OC_W   = 33;
    localparam int DIR_W  = 18;
    localparam int DIST_W = 31;
    localparam int NRM_W  = 16;

    // normal normalization
    localparam int NORM_FRAC = 14;
    localparam int M_W       = 30;
    localparam int LEN_W     = M_W + 1;
    localparam int Q_W       = NORM_FRAC + 1;
    localparam int N_W       = M_W + NORM_FRAC + 1;

    // per ray vectors carried down the pipe
    typedef struct packed {
        logic [2:0][OC_W-1:0]  oc;
        logic [2:0][DIR_W-1:0] d;
    } ray_ctx_t;

endpackage

### sv/rsi_isqrt.sv
module rsi_isqrt
#(
    parameter int OUT_W  = 31,
    parameter int SIDE_W = 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*OUT_W-1:0]  rad,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [OUT_W-1:0]    root,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int RAD_W = 2 * OUT_W;
    localparam int REM_W = OUT_W + 2;

    logic              vld_reg  [1:OUT_W];
    logic [RAD_W-1:0]  rad_reg  [1:OUT_W];
    logic [REM_W-1:0]  rem_reg  [1:OUT_W];
    logic [OUT_W-1:0]  root_reg [1:OUT_W];
    logic [SIDE_W-1:0] side_reg [1:OUT_W];

    // one root bit per stage, two radicand bits shifted in each time
    for (genvar k = 1; k <= OUT_W; k++)
    begin : g_stage
        logic              v_src;
        logic [RAD_W-1:0]  rad_src;
        logic [REM_W-1:0]  rem_src;
        logic [OUT_W-1:0]  root_src;
        logic [SIDE_W-1:0] side_src;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 1)
        begin : g_head
            assign v_src    = in_valid;
            assign rad_src  = rad;
            assign rem_src  = '0;
            assign root_src = '0;
            assign side_src = side_in;
        end
        else
        begin : g_body
            assign v_src    = vld_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        assign rem_sh = {rem_src[REM_W-3:0], rad_src[RAD_W-1 -: 2]};
        assign trial  = {root_src, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= {rad_src[RAD_W-3:0], 2'b00};
                rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_src[OUT_W-2:0], ge};
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = vld_reg[OUT_W];
    assign root      = root_reg[OUT_W];
    assign side_out  = side_reg[OUT_W];

endmodule

### sv/rsi_div.sv
module rsi_div
    import rsi_pkg::*;
#(
    parameter int QW     = Q_W,
    parameter int NW     = N_W,
    parameter int DW     = LEN_W,
    parameter int SIDE_W = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2:0][NW-1:0]   num,
    input  logic [DW-1:0]        den,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic [2:0][QW-1:0]   quo,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int CW = (DW + QW > NW) ? DW + QW : NW;

    logic                vld_reg  [1:QW];
    logic [2:0][NW-1:0]  rem_reg  [1:QW];
    logic [2:0][QW-1:0]  quo_reg  [1:QW];
    logic [DW-1:0]       den_reg  [1:QW];
    logic [SIDE_W-1:0]   side_reg [1:QW];

    // restoring division, one quotient bit per stage, three lanes share the divisor
    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        logic                v_src;
        logic [2:0][NW-1:0]  rem_src;
        logic [2:0][QW-1:0]  quo_src;
        logic [DW-1:0]       den_src;
        logic [SIDE_W-1:0]   side_src;
        logic [2:0][NW-1:0]  rem_new;
        logic [2:0][QW-1:0]  quo_new;

        if (k == 1)
        begin : g_head
            assign v_src    = in_valid;
            assign rem_src  = num;
            assign quo_src  = '0;
            assign den_src  = den;
            assign side_src = side_in;
        end
        else
        begin : g_body
            assign v_src    = vld_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign quo_src  = quo_reg[k-1];
            assign den_src  = den_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        always_comb
        begin
            logic [CW-1:0] dsh;
            logic [CW-1:0] rx;
            logic          ge;
            dsh = CW'(den_src) << (QW - k);
            for (int l = 0; l < 3; l++)
            begin
                rx         = CW'(rem_src[l]);
                ge         = (rx >= dsh);
                rem_new[l] = ge ? NW'(rx - dsh) : rem_src[l];
                quo_new[l] = {quo_src[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_new;
                quo_reg[k]  <= quo_new;
                den_reg[k]  <= den_src;
                side_reg[k] <= side_src;
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = quo_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

### sv/ray_sphere_intersect.sv
// channel  | handshake              | words
// ---------+------------------------+---------------------------------------------
// in       | in_valid / in_ready    | origin_x/y/z, dir_x/y/z
// out      | out_valid / out_ready  | hit, hit_distance, normal_x/y/z, hit_material
// cfg      | cfg_we                 | cfg_addr, cfg_data
//
// one ray enters per cycle while the output is not held; the latency is set by the two
// bit-per-stage root pipes and the divide pipe
// reset clears every valid bit and loads the register reset values
// the whole pipe holds while a result waits at the output, nothing is lost or repeated
module ray_sphere_intersect
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [31:0]       origin_x,
    input  logic signed [31:0]       origin_y,
    input  logic signed [31:0]       origin_z,
    input  logic signed [DIR_W-1:0]  dir_x,
    input  logic signed [DIR_W-1:0]  dir_y,
    input  logic signed [DIR_W-1:0]  dir_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     hit,
    output logic [DIST_W-1:0]        hit_distance,
    output logic signed [NRM_W-1:0]  normal_x,
    output logic signed [NRM_W-1:0]  normal_y,
    output logic signed [NRM_W-1:0]  normal_z,
    output logic [7:0]               hit_material
);

    localparam int F      = FRAC_BITS;
    localparam int P_W    = OC_W + DIR_W;
    localparam int B_W    = P_W + 2;
    localparam int SQO_W  = 2 * OC_W;
    localparam int R2_W   = 62;
    localparam int U_W    = SQO_W + 3;
    localparam int BA_W   = B_W;
    localparam int AL_W   = 27;
    localparam int AH_W   = BA_W - AL_W;
    localparam int B2_W   = 2 * BA_W;
    localparam int SQ_W   = (((U_W + 2 * F > B2_W) ? U_W + 2 * F : B2_W) + 2) / 2;
    localparam int DISC_W = 2 * SQ_W;
    localparam int T_W    = SQ_W + 2;
    localparam int TL_W   = T_W / 2;
    localparam int TH_W   = T_W - TL_W;
    localparam int LO_W   = DIR_W + TL_W + 1;
    localparam int HI_W   = DIR_W + TH_W;
    localparam int DT_W   = DIR_W + T_W;
    localparam int NV_W   = ((OC_W + 2 * F > DT_W) ? OC_W + 2 * F : DT_W) + 1;
    localparam int SH_W   = $clog2(NV_W + 1);
    localparam int SUM_W  = 2 * LEN_W;
    localparam int CTX_W  = $bits(ray_ctx_t);
    localparam int SA_W   = B_W + CTX_W + 1;
    localparam int SB_W   = 3 * M_W + 3 + 1 + DIST_W;
    localparam int SC_W   = 3 + 1 + DIST_W + 1;

    localparam logic signed [T_W-1:0] EPS = T_W'((64'd1 << (2 * F)) / 64'd10000);
    localparam logic [Q_W-1:0] NORM_ONE = Q_W'(1 << NORM_FRAC);
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // configuration registers
    logic signed [31:0] center_reg [3];
    logic [30:0]        radius_reg;
    logic [7:0]         material_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= RADIUS_RESET;
            material_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_CENTER_X: center_reg[0] <= cfg_data;
                REG_CENTER_Y: center_reg[1] <= cfg_data;
                REG_CENTER_Z: center_reg[2] <= cfg_data;
                REG_RADIUS:   radius_reg    <= cfg_data[30:0];
                REG_MATERIAL: material_reg  <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // global advance: the pipe moves unless the output word is held
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    logic signed [31:0]      org [3];
    logic signed [DIR_W-1:0] dir [3];

    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;

    // front stage registers
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    ray_ctx_t s1_ctx_reg, s2_ctx_reg, s3_ctx_reg, s4_ctx_reg, s5_ctx_reg, s6_ctx_reg;
    ray_ctx_t s7_ctx_reg;
    logic signed [P_W-1:0]   s2_p_reg   [3];
    logic signed [SQO_W-1:0] s2_osq_reg [3];
    logic [R2_W-1:0]         s2_r2_reg;
    logic signed [B_W-1:0]   s3_b_reg, s4_b_reg, s5_b_reg, s6_b_reg, s7_b_reg;
    logic signed [U_W-1:0]   s3_u_reg, s4_u_reg, s5_u_reg, s6_u_reg;
    logic [BA_W-1:0]         s4_babs_reg;
    logic [2*AH_W-1:0]       s5_hh_reg;
    logic [AH_W+AL_W-1:0]    s5_hl_reg;
    logic [2*AL_W-1:0]       s5_ll_reg;
    logic [B2_W-1:0]         s6_b2_reg;
    logic signed [DISC_W-1:0] s7_disc_reg;

    // back stage registers
    logic v8_reg, v9_reg, v10_reg, v11_reg, v12_reg, v13_reg, v14_reg, v15_reg, v16_reg;
    logic signed [T_W-1:0]   s8_t_reg;
    logic                    s8_miss_reg, s9_miss_reg, s10_miss_reg, s11_miss_reg;
    logic                    s12_miss_reg, s13_miss_reg, s14_miss_reg, s15_miss_reg;
    ray_ctx_t                s8_ctx_reg, s9_ctx_reg;
    logic signed [LO_W-1:0]  s9_lo_reg [3];
    logic signed [HI_W-1:0]  s9_hi_reg [3];
    logic [DIST_W-1:0]       s9_dist_reg, s10_dist_reg, s11_dist_reg, s12_dist_reg;
    logic [DIST_W-1:0]       s13_dist_reg, s14_dist_reg, s15_dist_reg;
    logic signed [NV_W-1:0]  s10_nv_reg [3];
    logic [2:0][NV_W-1:0]    s11_mag_reg, s12_mag_reg;
    logic [2:0]              s11_neg_reg, s12_neg_reg, s13_neg_reg, s14_neg_reg, s15_neg_reg;
    logic [SH_W-1:0]         s12_s_reg;
    logic [2:0][M_W-1:0]     s13_m_reg, s14_m_reg, s15_m_reg;
    logic [2*M_W-1:0]        s14_sq_reg [3];
    logic [SUM_W-1:0]        s15_sum_reg;
    logic [2:0][N_W-1:0]     s16_num_reg;
    logic [LEN_W-1:0]        s16_den_reg;
    logic [SC_W-1:0]         s16_side_reg;

    // output word
    logic                    hit_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [NRM_W-1:0]        nrm_reg [3];
    logic [7:0]              mat_reg;

    // valid bits
    logic va_valid, vb_valid, vc_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            v9_reg <= 1'b0; v10_reg <= 1'b0; v11_reg <= 1'b0; v12_reg <= 1'b0;
            v13_reg <= 1'b0; v14_reg <= 1'b0; v15_reg <= 1'b0; v16_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg;
            v8_reg <= va_valid; v9_reg <= v8_reg; v10_reg <= v9_reg; v11_reg <= v10_reg;
            v12_reg <= v11_reg; v13_reg <= v12_reg; v14_reg <= v13_reg; v15_reg <= v14_reg;
            v16_reg <= vb_valid;
            out_valid_reg <= vc_valid;
        end
    end

    // offsets, dot products, squares, discriminant
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_ctx_reg.oc[i] <= OC_W'(org[i]) - OC_W'(center_reg[i]);
                s1_ctx_reg.d[i]  <= dir[i];
                s2_p_reg[i]      <= $signed(s1_ctx_reg.oc[i]) * $signed(s1_ctx_reg.d[i]);
                s2_osq_reg[i]    <= $signed(s1_ctx_reg.oc[i]) * $signed(s1_ctx_reg.oc[i]);
            end
            s2_r2_reg  <= radius_reg * radius_reg;
            s2_ctx_reg <= s1_ctx_reg;

            s3_b_reg   <= B_W'(s2_p_reg[0]) + B_W'(s2_p_reg[1]) + B_W'(s2_p_reg[2]);
            s3_u_reg   <= U_W'(s2_osq_reg[0]) + U_W'(s2_osq_reg[1]) + U_W'(s2_osq_reg[2])
                          - $signed({{(U_W-R2_W){1'b0}}, s2_r2_reg});
            s3_ctx_reg <= s2_ctx_reg;

            s4_babs_reg <= s3_b_reg[B_W-1] ? BA_W'(-s3_b_reg) : BA_W'(s3_b_reg);
            s4_b_reg    <= s3_b_reg;
            s4_u_reg    <= s3_u_reg;
            s4_ctx_reg  <= s3_ctx_reg;

            s5_hh_reg  <= s4_babs_reg[BA_W-1:AL_W] * s4_babs_reg[BA_W-1:AL_W];
            s5_hl_reg  <= s4_babs_reg[BA_W-1:AL_W] * s4_babs_reg[AL_W-1:0];
            s5_ll_reg  <= s4_babs_reg[AL_W-1:0] * s4_babs_reg[AL_W-1:0];
            s5_b_reg   <= s4_b_reg;
            s5_u_reg   <= s4_u_reg;
            s5_ctx_reg <= s4_ctx_reg;

            s6_b2_reg  <= (B2_W'(s5_hh_reg) << (2 * AL_W)) + (B2_W'(s5_hl_reg) << (AL_W + 1))
                          + B2_W'(s5_ll_reg);
            s6_b_reg   <= s5_b_reg;
            s6_u_reg   <= s5_u_reg;
            s6_ctx_reg <= s5_ctx_reg;

            s7_disc_reg <= $signed({{(DISC_W-B2_W){1'b0}}, s6_b2_reg})
                           - (DISC_W'(s6_u_reg) <<< (2 * F));
            s7_b_reg    <= s6_b_reg;
            s7_ctx_reg  <= s6_ctx_reg;
        end
    end

    // root of the discriminant
    logic [DISC_W-1:0]  sa_rad;
    logic [SA_W-1:0]    sa_side_in, sa_side_out;
    logic [SQ_W-1:0]    sa_root;
    logic signed [B_W-1:0] a_b;
    ray_ctx_t           a_ctx;
    logic               a_miss;

    assign sa_rad     = s7_disc_reg[DISC_W-1] ? '0 : s7_disc_reg;
    assign sa_side_in = {s7_b_reg, s7_ctx_reg, s7_disc_reg[DISC_W-1]};
    assign {a_b, a_ctx, a_miss} = sa_side_out;

    rsi_isqrt #(
        .OUT_W  (SQ_W),
        .SIDE_W (SA_W)
    ) u_disc_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v7_reg),
        .rad       (sa_rad),
        .side_in   (sa_side_in),
        .out_valid (va_valid),
        .root      (sa_root),
        .side_out  (sa_side_out)
    );

    // root selection against epsilon
    logic signed [T_W-1:0] t_near, t_far;
    logic                  near_ok, far_ok;

    always_comb
    begin
        logic signed [T_W-1:0] nb;
        logic signed [T_W-1:0] sqx;
        nb      = -T_W'(a_b);
        sqx     = $signed({2'b00, sa_root});
        t_near  = nb - sqx;
        t_far   = nb + sqx;
        near_ok = t_near > EPS;
        far_ok  = t_far > EPS;
    end

    // distance clamp
    logic [T_W-1:0] t_int;

    assign t_int = s8_t_reg >> F;

    // hit point, normal magnitudes, common shift
    logic [NV_W-1:0] mag_or;
    logic [SH_W-1:0] lead;
    logic [SH_W-1:0] norm_shift;

    always_comb
    begin
        mag_or = s11_mag_reg[0] | s11_mag_reg[1] | s11_mag_reg[2];
        lead   = '0;
        for (int j = 0; j < NV_W; j++)
        begin
            if (mag_or[j])
            begin
                lead = SH_W'(j + 1);
            end
        end
        norm_shift = (lead > SH_W'(M_W)) ? (lead - SH_W'(M_W)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_t_reg    <= near_ok ? t_near : t_far;
            s8_miss_reg <= a_miss || (!near_ok && !far_ok);
            s8_ctx_reg  <= a_ctx;

            for (int i = 0; i < 3; i++)
            begin
                s9_lo_reg[i] <= $signed(s8_ctx_reg.d[i]) * $signed({1'b0, s8_t_reg[TL_W-1:0]});
                s9_hi_reg[i] <= $signed(s8_ctx_reg.d[i]) * $signed(s8_t_reg[T_W-1:TL_W]);
            end
            s9_dist_reg <= (|t_int[T_W-1:DIST_W]) ? DIST_MAX : t_int[DIST_W-1:0];
            s9_miss_reg <= s8_miss_reg;
            s9_ctx_reg  <= s8_ctx_reg;

            for (int i = 0; i < 3; i++)
            begin
                s10_nv_reg[i] <= (NV_W'($signed(s9_ctx_reg.oc[i])) <<< (2 * F))
                                 + (NV_W'(s9_hi_reg[i]) <<< TL_W) + NV_W'(s9_lo_reg[i]);
            end
            s10_miss_reg <= s9_miss_reg;
            s10_dist_reg <= s9_dist_reg;

            for (int i = 0; i < 3; i++)
            begin
                s11_neg_reg[i] <= s10_nv_reg[i][NV_W-1];
                s11_mag_reg[i] <= s10_nv_reg[i][NV_W-1] ? NV_W'(-s10_nv_reg[i])
                                                        : NV_W'(s10_nv_reg[i]);
            end
            s11_miss_reg <= s10_miss_reg;
            s11_dist_reg <= s10_dist_reg;

            s12_mag_reg  <= s11_mag_reg;
            s12_s_reg    <= norm_shift;
            s12_neg_reg  <= s11_neg_reg;
            s12_miss_reg <= s11_miss_reg;
            s12_dist_reg <= s11_dist_reg;

            for (int i = 0; i < 3; i++)
            begin
                s13_m_reg[i] <= M_W'(s12_mag_reg[i] >> s12_s_reg);
            end
            s13_neg_reg  <= s12_neg_reg;
            s13_miss_reg <= s12_miss_reg;
            s13_dist_reg <= s12_dist_reg;

            for (int i = 0; i < 3; i++)
            begin
                s14_sq_reg[i] <= s13_m_reg[i] * s13_m_reg[i];
            end
            s14_m_reg    <= s13_m_reg;
            s14_neg_reg  <= s13_neg_reg;
            s14_miss_reg <= s13_miss_reg;
            s14_dist_reg <= s13_dist_reg;

            s15_sum_reg  <= SUM_W'(s14_sq_reg[0]) + SUM_W'(s14_sq_reg[1])
                            + SUM_W'(s14_sq_reg[2]);
            s15_m_reg    <= s14_m_reg;
            s15_neg_reg  <= s14_neg_reg;
            s15_miss_reg <= s14_miss_reg;
            s15_dist_reg <= s14_dist_reg;
        end
    end

    // normal length
    logic [SB_W-1:0]        sb_side_in, sb_side_out;
    logic [LEN_W-1:0]       sb_len;
    logic [2:0][M_W-1:0]    b_m;
    logic [2:0]             b_neg;
    logic                   b_miss;
    logic [DIST_W-1:0]      b_dist;

    assign sb_side_in = {s15_m_reg, s15_neg_reg, s15_miss_reg, s15_dist_reg};
    assign {b_m, b_neg, b_miss, b_dist} = sb_side_out;

    rsi_isqrt #(
        .OUT_W  (LEN_W),
        .SIDE_W (SB_W)
    ) u_len_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v15_reg),
        .rad       (s15_sum_reg),
        .side_in   (sb_side_in),
        .out_valid (vb_valid),
        .root      (sb_len),
        .side_out  (sb_side_out)
    );

    // rounded quotients set up
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s16_num_reg[i] <= (N_W'(b_m[i]) << NORM_FRAC) + N_W'(sb_len >> 1);
            end
            s16_den_reg  <= sb_len;
            s16_side_reg <= {b_neg, b_miss, b_dist, (sb_len == '0)};
        end
    end

    logic [2:0][Q_W-1:0]  c_quo;
    logic [SC_W-1:0]      c_side;
    logic [2:0]           c_neg;
    logic                 c_miss;
    logic [DIST_W-1:0]    c_dist;
    logic                 c_lz;

    assign {c_neg, c_miss, c_dist, c_lz} = c_side;

    rsi_div #(
        .QW     (Q_W),
        .NW     (N_W),
        .DW     (LEN_W),
        .SIDE_W (SC_W)
    ) u_norm_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v16_reg),
        .num       (s16_num_reg),
        .den       (s16_den_reg),
        .side_in   (s16_side_reg),
        .out_valid (vc_valid),
        .quo       (c_quo),
        .side_out  (c_side)
    );

    // output word: clamp, sign, zero on miss or zero length
    always_ff @(posedge clk)
    begin
        logic [Q_W-1:0] qc;
        if (adv)
        begin
            hit_reg  <= !c_miss;
            dist_reg <= c_miss ? '0 : c_dist;
            mat_reg  <= c_miss ? '0 : material_reg;
            for (int i = 0; i < 3; i++)
            begin
                qc = (c_quo[i] > NORM_ONE) ? NORM_ONE : c_quo[i];
                if (c_lz || c_miss)
                begin
                    qc = '0;
                end
                nrm_reg[i] <= c_neg[i] ? NRM_W'(-{1'b0, qc}) : NRM_W'({1'b0, qc});
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign hit_distance = dist_reg;
    assign normal_x     = nrm_reg[0];
    assign normal_y     = nrm_reg[1];
    assign normal_z     = nrm_reg[2];
    assign hit_material = mat_reg;

endmodule

### sv/rsi_checker.sv
module rsi_checker
    import rsi_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     cfg_we,
    input logic [CFG_ADDR_W-1:0]    cfg_addr,
    input logic [CFG_DATA_W-1:0]    cfg_data,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic signed [31:0]       origin_x,
    input logic signed [31:0]       origin_y,
    input logic signed [31:0]       origin_z,
    input logic signed [DIR_W-1:0]  dir_x,
    input logic signed [DIR_W-1:0]  dir_y,
    input logic signed [DIR_W-1:0]  dir_z,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     hit,
    input logic [DIST_W-1:0]        hit_distance,
    input logic signed [NRM_W-1:0]  normal_x,
    input logic signed [NRM_W-1:0]  normal_y,
    input logic signed [NRM_W-1:0]  normal_z,
    input logic [7:0]               hit_material
);

    // a held result keeps its hit, distance, normal_x and material
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_distance)
            && $stable(normal_x) && $stable(hit_material))
        else $error("held result changed");

    // input side stalls exactly when the output word is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    // a miss reports all zeros
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> hit_distance == '0 && normal_x == '0 && normal_y == '0
            && normal_z == '0 && hit_material == '0)
        else $error("miss with nonzero fields");

    // normal components stay within one in Q2.14
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384
            && normal_y <= 16'sd16384 && normal_y >= -16'sd16384
            && normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
        else $error("normal component out of range");

endmodule

bind ray_sphere_intersect rsi_checker u_rsi_checker (.*);
